/* rtl/core/assert_macros.svh */
// Assertion macros shared by the block pool allocator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while out of reset.
`define FBPA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication checked while out of reset.
`define FBPA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/fbpa_pkg.sv */
// Types, constants and codes of the fixed block pool allocator.
// No dependencies; imported by the allocator and divider modules.
package fbpa_pkg;

  localparam int unsigned ADDR_W         = 32;
  localparam int unsigned SIZE_W         = 16;
  localparam int unsigned CNT_W          = 9;
  localparam int unsigned CNT_MAX        = (2 ** CNT_W) - 1;
  localparam int unsigned IDX_OUT_W      = 8;
  localparam int unsigned ALIGN_BITS     = 3;
  localparam int unsigned STRIDE_W       = SIZE_W + 1 - ALIGN_BITS;
  localparam int unsigned DVD_W          = ADDR_W - ALIGN_BITS;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned MAX_BLOCKS_DEF = 256;

  localparam logic [SIZE_W-1:0] SIZE_MIN  = SIZE_W'(8);
  localparam logic [SIZE_W:0]   ROUND_ADD = (SIZE_W + 1)'(7);

  localparam logic [CFG_IDX_W-1:0] REG_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SIZE  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = CFG_IDX_W'(2);

  localparam logic [ADDR_W-1:0] BASE_RST  = '0;
  localparam logic [SIZE_W-1:0] SIZE_RST  = SIZE_W'(8);
  localparam logic [CNT_W-1:0]  COUNT_RST = CNT_W'(256);

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EXHAUSTED = 2'd1,
    STATUS_INVALID   = 2'd2,
    STATUS_DOUBLE    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC,
    ST_ADDR,
    ST_DIV,
    ST_FCHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] address;
  } fbpa_in_t;

  typedef struct packed {
    status_t              status;
    logic [ADDR_W-1:0]    block_address;
    logic [IDX_OUT_W-1:0] block_index;
    logic [CNT_W-1:0]     blocks_free;
  } fbpa_out_t;

  typedef struct packed {
    logic                start;
    logic [DVD_W-1:0]    dividend;
    logic [STRIDE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DVD_W-1:0]    quo;
    logic [STRIDE_W-1:0] rem;
  } div_rsp_t;

endpackage

/* rtl/core/fixed_block_pool_allocator.sv */
// Channel  Dir  Handshake              Payload
// in_      in   in_valid / in_stall    fbpa_in_t  (op, address)
// out_     out  out_valid / out_stall  fbpa_out_t (status, address, index, blocks_free)
// cfg_     in   cfg_we                 cfg_index, cfg_wdata
// Allocate: pop the head entry, form the block address, then load the output register.
// Free: index from the 29-bit divider (1 bit/cycle), then the mark check; out of range or not a
//   stride multiple: no mark check. Exhausted, zero, below base or unaligned: straight to output.
// After reset and each base, size or count write the link RAM is swept (MAX_BLOCKS entries), in_stall high.
// A finished result waits in the output register; the next request is taken meanwhile,
//   and its result holds in_stall high until the output register frees.
// Depends on fbpa_pkg, fbpa_ram, fbpa_div and assert_macros.svh.
`include "assert_macros.svh"

module fixed_block_pool_allocator #(
  parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  fbpa_pkg::fbpa_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fbpa_pkg::fbpa_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import fbpa_pkg::*;

  localparam int unsigned IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned LINK_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned MEM_W  = LINK_W + 1;
  localparam int unsigned PROD_W = IDX_W + STRIDE_W;
  localparam int unsigned CW     = (LINK_W > CNT_W) ? LINK_W : CNT_W;
  localparam int unsigned CAP    = (MAX_BLOCKS < CNT_MAX) ? MAX_BLOCKS : CNT_MAX;
  localparam logic [CNT_W-1:0]  CAP_C  = CNT_W'(CAP);
  localparam logic [LINK_W-1:0] LAST_C = LINK_W'(MAX_BLOCKS - 1);

  state_t                state_r, state_nxt;
  logic [LINK_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]      total_r, total_nxt;
  logic [LINK_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [IDX_W-1:0]      fidx_r, fidx_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]     res_addr_r, res_addr_nxt;
  logic [IDX_OUT_W-1:0]  res_idx_r, res_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  fbpa_out_t             out_r, out_nxt;
  logic [ADDR_W-1:0]     base_r;
  logic [SIZE_W-1:0]     size_r;
  logic [CNT_W-1:0]      count_r;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [MEM_W-1:0]      ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [MEM_W-1:0]      ram_rdata;

  div_req_t              div_req;
  div_rsp_t              div_rsp;

  logic [CNT_W-1:0]      n_eff;
  logic [CNT_W-1:0]      free_cnt;
  logic [SIZE_W-1:0]     size_eff;
  logic [SIZE_W:0]       size_round;
  logic [STRIDE_W-1:0]   stride8;
  logic [ADDR_W-1:0]     addr_off;
  logic                  fast_bad;
  logic                  head_empty;
  logic                  q_bad;
  logic                  out_free;
  logic                  cfg_hit;
  logic [IDX_W-1:0]      head_idx;
  logic                  in_fchk;
  logic                  in_div;
  logic                  err_out;
  logic                  err_clean;

  fbpa_ram #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (MEM_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fbpa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    n_eff      = (count_r > CAP_C) ? CAP_C : count_r;
    free_cnt   = (total_r >= n_eff) ? '0 : n_eff - total_r;
    size_eff   = (size_r < SIZE_MIN) ? SIZE_MIN : size_r;
    size_round = {1'b0, size_eff} + ROUND_ADD;
    stride8    = size_round[SIZE_W:ALIGN_BITS];
    addr_off   = in_data.address - base_r;
    fast_bad   = (in_data.address == '0) || (in_data.address < base_r) ||
                 (addr_off[ALIGN_BITS-1:0] != '0);
    head_empty = CW'(head_r) >= CW'(n_eff);
    head_idx   = head_r[IDX_W-1:0];
    q_bad      = (div_rsp.rem != '0) || (div_rsp.quo >= DVD_W'(n_eff));
    out_free   = !out_valid_r || !out_stall;
    cfg_hit    = cfg_we && ((cfg_index == REG_BASE) || (cfg_index == REG_SIZE) ||
                            (cfg_index == REG_COUNT));
    in_stall   = (state_r != ST_IDLE);
    in_fchk    = (state_r == ST_FCHK);
    in_div     = (state_r == ST_DIV);
    err_out    = out_valid_r && (out_r.status != STATUS_OK);
    err_clean  = (out_r.block_index == '0) && (out_r.block_address == '0);
  end

  always_comb begin
    state_nxt        = state_r;
    head_nxt         = head_r;
    total_nxt        = total_r;
    clr_cnt_nxt      = clr_cnt_r;
    prod_nxt         = prod_r;
    fidx_nxt         = fidx_r;
    res_status_nxt   = res_status_r;
    res_addr_nxt     = res_addr_r;
    res_idx_nxt      = res_idx_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_nxt          = out_r;
    ram_we           = 1'b0;
    ram_waddr        = head_idx;
    ram_wdata        = '0;
    ram_raddr        = head_idx;
    div_req.start    = 1'b0;
    div_req.dividend = addr_off[ADDR_W-1:ALIGN_BITS];
    div_req.divisor  = stride8;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r[IDX_W-1:0];
        ram_wdata = {1'b0, clr_cnt_r + LINK_W'(1)};
        if (clr_cnt_r == LAST_C) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + LINK_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.op == OP_ALLOC) begin
            if (head_empty) begin
              res_status_nxt = STATUS_EXHAUSTED;
              res_addr_nxt   = '0;
              res_idx_nxt    = '0;
              state_nxt      = ST_DONE;
            end else begin
              state_nxt = ST_ALLOC;
            end
          end else if (fast_bad) begin
            res_status_nxt = STATUS_INVALID;
            res_addr_nxt   = '0;
            res_idx_nxt    = '0;
            state_nxt      = ST_DONE;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = ST_DIV;
          end
        end
      end
      ST_ALLOC: begin
        // pop: mark head allocated, follow its link
        ram_we    = 1'b1;
        ram_waddr = head_idx;
        ram_wdata = {1'b1, ram_rdata[LINK_W-1:0]};
        head_nxt  = ram_rdata[LINK_W-1:0];
        total_nxt = total_r + CNT_W'(1);
        prod_nxt  = {{STRIDE_W{1'b0}}, head_idx} * {{IDX_W{1'b0}}, stride8};
        fidx_nxt  = head_idx;
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        res_status_nxt = STATUS_OK;
        res_addr_nxt   = base_r + ADDR_W'({prod_r, {ALIGN_BITS{1'b0}}});
        res_idx_nxt    = IDX_OUT_W'(fidx_r);
        state_nxt      = ST_DONE;
      end
      ST_DIV: begin
        ram_raddr = div_rsp.quo[IDX_W-1:0];
        if (div_rsp.done) begin
          if (q_bad) begin
            res_status_nxt = STATUS_INVALID;
            res_addr_nxt   = '0;
            res_idx_nxt    = '0;
            state_nxt      = ST_DONE;
          end else begin
            fidx_nxt  = div_rsp.quo[IDX_W-1:0];
            state_nxt = ST_FCHK;
          end
        end
      end
      ST_FCHK: begin
        res_addr_nxt = '0;
        if (!ram_rdata[LINK_W]) begin
          res_status_nxt = STATUS_DOUBLE;
          res_idx_nxt    = '0;
        end else begin
          // push: block links to old head
          ram_we         = 1'b1;
          ram_waddr      = fidx_r;
          ram_wdata      = {1'b0, head_r};
          head_nxt       = LINK_W'(fidx_r);
          total_nxt      = (total_r != '0) ? total_r - CNT_W'(1) : total_r;
          res_status_nxt = STATUS_OK;
          res_idx_nxt    = IDX_OUT_W'(fidx_r);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_nxt.status        = res_status_r;
          out_nxt.block_address = res_addr_r;
          out_nxt.block_index   = res_idx_r;
          out_nxt.blocks_free   = free_cnt;
          out_valid_nxt         = 1'b1;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase

    if (cfg_hit) begin
      state_nxt   = ST_CLEAR;
      clr_cnt_nxt = '0;
      head_nxt    = '0;
      total_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      head_r      <= '0;
      total_r     <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      base_r      <= BASE_RST;
      size_r      <= SIZE_RST;
      count_r     <= COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      total_r     <= total_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        priority case (cfg_index)
          REG_BASE:  base_r  <= cfg_wdata[ADDR_W-1:0];
          REG_SIZE:  size_r  <= cfg_wdata[SIZE_W-1:0];
          REG_COUNT: count_r <= cfg_wdata[CNT_W-1:0];
          default:   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r       <= prod_nxt;
    fidx_r       <= fidx_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_idx_r    <= res_idx_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `FBPA_ASSERT(a_total_le_count, clk, rst_n, total_r <= n_eff, "allocated total above count")
  `FBPA_ASSERT_IMPL(a_fchk_after_div, clk, rst_n, in_fchk, $past(in_div), "mark check w/o read")
  `FBPA_ASSERT_IMPL(a_err_zero_fields, clk, rst_n, err_out, err_clean, "error result fields")

endmodule

/* rtl/core/fbpa_ram.sv */
// Single-port-write, single-port-read synchronous RAM, registered read data.
// Depends on nothing; holds the free-list links and allocated marks.
module fbpa_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 10,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

/* rtl/core/fbpa_div.sv */
// Restoring divider, one quotient bit per cycle, for offset over stride.
// Depends on fbpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fbpa_div (
  input  logic               clk,
  input  logic               rst_n,
  input  fbpa_pkg::div_req_t req,
  output fbpa_pkg::div_rsp_t rsp
);
  import fbpa_pkg::*;

  localparam int unsigned CNT_DW = $clog2(DVD_W + 1);

  logic                busy_r, busy_nxt;
  logic [CNT_DW-1:0]   cnt_r, cnt_nxt;
  logic [DVD_W-1:0]    quo_r, quo_nxt;
  logic [STRIDE_W-1:0] rem_r, rem_nxt;
  logic [STRIDE_W-1:0] dvs_r, dvs_nxt;
  logic [STRIDE_W:0]   trial;
  logic [STRIDE_W:0]   diff;

  always_comb begin
    trial    = {rem_r, quo_r[DVD_W-1]};
    diff     = trial - {1'b0, dvs_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_DW'(DVD_W);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        if (trial >= {1'b0, dvs_r}) begin
          rem_nxt = diff[STRIDE_W-1:0];
          quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[STRIDE_W-1:0];
          quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CNT_DW'(1);
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = busy_r && (cnt_r == '0);
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

  `FBPA_ASSERT_IMPL(a_start_when_free, clk, rst_n, req.start, !busy_r, "divider restarted")
  `FBPA_ASSERT_IMPL(a_rem_below_dvs, clk, rst_n, busy_r, rem_r < dvs_r, "partial remainder")
  `FBPA_ASSERT(a_cnt_range, clk, rst_n, cnt_r <= CNT_DW'(DVD_W), "divider count range")

endmodule

/* bench/fixed_block_pool_allocator_tb.sv */
// Testbench for fixed_block_pool_allocator: directed and random alloc/free requests,
// predicted by a free-list mirror kept in a scoreboard class, under random idling.
// Depends on fbpa_pkg and the allocator RTL.
`timescale 1ns / 100ps

module fixed_block_pool_allocator_tb;
  import fbpa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
  localparam int unsigned POOL_DEPTH = 256;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_REQUESTS = 48;

  class pool_mirror;
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  head;
    logic [CNT_W-1:0]  link [POOL_DEPTH];
    bit                taken [POOL_DEPTH];
    int unsigned       in_use;
    fbpa_out_t         pending_results [$];
    int unsigned       errors;

    function new();
      base = BASE_RST;
      size_reg = SIZE_RST;
      count_reg = COUNT_RST;
      errors = 0;
      clear_pool();
    endfunction

    function void clear_pool();
      head = '0;
      for (int i = 0; i < POOL_DEPTH; i++) begin
        link[i] = CNT_W'(i + 1);
        taken[i] = 1'b0;
      end
      in_use = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BASE: base = data[ADDR_W-1:0];
        REG_SIZE: size_reg = data[SIZE_W-1:0];
        REG_COUNT: count_reg = data[CNT_W-1:0];
        default: return;
      endcase
      clear_pool();
    endfunction

    function int unsigned live_count();
      return (count_reg > POOL_DEPTH) ? POOL_DEPTH : int'(count_reg);
    endfunction

    function longint unsigned stride();
      longint unsigned bs;
      bs = (size_reg < 8) ? 8 : size_reg;
      return (bs + 7) & ~64'd7;
    endfunction

    function void note_request(fbpa_in_t req);
      fbpa_out_t         want;
      int unsigned       n;
      int unsigned       idx;
      longint unsigned   st;
      longint unsigned   off;
      n = live_count();
      st = stride();
      want = '0;
      want.status = STATUS_OK;
      if (req.op == OP_ALLOC) begin
        if (head >= n) begin
          want.status = STATUS_EXHAUSTED;
        end else begin
          idx = head;
          head = link[idx];
          taken[idx] = 1'b1;
          in_use++;
          want.block_address = base + ADDR_W'(idx * st);
          want.block_index = idx[IDX_OUT_W-1:0];
        end
      end else if (req.address == '0 || req.address < base) begin
        want.status = STATUS_INVALID;
      end else begin
        off = req.address - base;
        if (off % st != 0 || off / st >= n) begin
          want.status = STATUS_INVALID;
        end else begin
          idx = int'(off / st);
          if (!taken[idx]) begin
            want.status = STATUS_DOUBLE;
          end else begin
            taken[idx] = 1'b0;
            link[idx] = head;
            head = CNT_W'(idx);
            if (in_use > 0) in_use--;
            want.block_index = idx[IDX_OUT_W-1:0];
          end
        end
      end
      want.blocks_free = (in_use >= n) ? '0 : CNT_W'(n - in_use);
      pending_results.push_back(want);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      errors++;
      $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    endtask

    task check_result(fbpa_out_t got);
      fbpa_out_t want;
      if (pending_results.size() == 0) begin
        report("result with no request pending", got, 0);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.block_address !== want.block_address)
        report("block_address", got.block_address, want.block_address);
      if (got.block_index !== want.block_index)
        report("block_index", got.block_index, want.block_index);
      if (got.blocks_free !== want.blocks_free)
        report("blocks_free", got.blocks_free, want.blocks_free);
    endtask
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  fbpa_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  fbpa_out_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  bit          quiet = 1'b0;
  int unsigned cycle_count = 0;
  pool_mirror  sb = new();

  fixed_block_pool_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 20);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // in_valid stays high into the next request unless a gap follows or this is the last one
  task automatic send_request(op_t op, logic [ADDR_W-1:0] addr, bit last);
    fbpa_in_t req;
    req.op = op;
    req.address = addr;
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    if (last) begin
      in_valid <= 1'b0;
    end else if (!quiet && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  task automatic run_script(fbpa_in_t script [$]);
    for (int i = 0; i < script.size(); i++)
      send_request(script[i].op, script[i].address, i == script.size() - 1);
  endtask

  task automatic load_config(logic [CFG_DATA_W-1:0] base_word, logic [CFG_DATA_W-1:0] size_word,
                             logic [CFG_DATA_W-1:0] count_word, bit touch_spare);
    logic [CFG_IDX_W-1:0]  idx [$];
    logic [CFG_DATA_W-1:0] data [$];
    idx = '{REG_BASE, REG_SIZE, REG_COUNT};
    data = '{base_word, size_word, count_word};
    if (touch_spare) begin
      idx.push_back(REG_SPARE);
      data.push_back($urandom);
    end
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < idx.size(); i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= data[i];
      @(posedge clk);
      sb.write_reg(idx[i], data[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic fbpa_in_t pick_request();
    fbpa_in_t          req;
    int unsigned       n;
    int unsigned       roll;
    int unsigned       i;
    logic [ADDR_W-1:0] st;
    int unsigned       held [$];
    n = sb.live_count();
    st = ADDR_W'(sb.stride());
    for (i = 0; i < n; i++) begin
      if (sb.taken[i]) held.push_back(i);
    end
    roll = $urandom_range(99);
    req.address = $urandom;
    req.op = OP_FREE;
    if (roll < 50) begin
      req.op = OP_ALLOC;
    end else if (roll < 80 && held.size() > 0) begin
      req.address = sb.base + held[$urandom_range(held.size() - 1)] * st;
    end else if (roll < 88 && n > 0) begin
      req.address = sb.base + $urandom_range(n - 1) * st;
    end else if (roll < 94 && n > 0) begin
      req.address = sb.base + $urandom_range(n - 1) * st + $urandom_range(1, st - 1);
    end else if (roll < 97) begin
      req.address = sb.base + n * st;
    end
    return req;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_base();
    case ($urandom_range(5))
      0: return '0;
      1: return 32'hFFFF_FFF8 - ($urandom_range(64) << 3);
      2: return $urandom;
      default: return $urandom & ~32'h7;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_size();
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom & 32'hFFFF_0000;
    case ($urandom_range(4))
      0: return junk | $urandom_range(0, 7);
      1: return junk | 32'hFFFF;
      2: return junk | $urandom_range(0, 65535);
      default: return junk | $urandom_range(8, 64);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_count();
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom & 32'hFFFF_FE00;
    case ($urandom_range(7))
      0: return junk;
      1: return junk | 32'd256;
      2: return junk | $urandom_range(257, 511);
      3: return junk | $urandom_range(1, 32);
      default: return junk | $urandom_range(1, 8);
    endcase
  endfunction

  initial begin
    fbpa_in_t script [$];
    fbpa_in_t req;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: base 0, stride 8, 256 blocks
    script = '{
      '{OP_FREE, 32'h0000_0000}, '{OP_FREE, 32'h0000_0008},
      '{OP_ALLOC, 32'h0000_0000}, '{OP_ALLOC, 32'hFFFF_FFFF},
      '{OP_FREE, 32'h0000_0008}, '{OP_FREE, 32'h0000_0008},
      '{OP_ALLOC, 32'h5555_AAAA}, '{OP_FREE, 32'h0000_0000},
      '{OP_FREE, 32'h0000_000C}, '{OP_FREE, 32'h0000_0800},
      '{OP_FREE, 32'h0000_07F8}, '{OP_FREE, 32'hFFFF_FFF8}};
    run_script(script);

    // pool wraps past the top of the address space; drain it
    load_config(32'hFFFF_FFF0, 32'hABCD_0008, 32'h1234_5E04, 1'b1);
    script = '{
      '{OP_ALLOC, 32'h0}, '{OP_ALLOC, 32'h0}, '{OP_ALLOC, 32'h0}, '{OP_ALLOC, 32'h0},
      '{OP_ALLOC, 32'h0}, '{OP_FREE, 32'h0000_0008},
      '{OP_FREE, 32'hFFFF_FFF8}, '{OP_FREE, 32'hFFFF_FFF4}};
    run_script(script);

    // empty pool, block size below minimum
    load_config(32'h0000_0010, 32'h0000_0003, 32'h0000_0000, 1'b0);
    script = '{'{OP_ALLOC, 32'h0}, '{OP_FREE, 32'h0000_0010}};
    run_script(script);

    // largest block size, count above the built maximum
    load_config(32'h8000_0000, 32'h0000_FFFF, 32'h0000_01FF, 1'b0);
    script = '{
      '{OP_ALLOC, 32'h0}, '{OP_ALLOC, 32'h0},
      '{OP_FREE, 32'h8001_0000}, '{OP_FREE, 32'h8100_0000}};
    run_script(script);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_config(random_base(), random_size(), random_count(), p == RANDOM_PHASES - 1);
      quiet = (p == 3 || p == 4);
      for (int k = 0; k < PHASE_REQUESTS; k++) begin
        req = pick_request();
        send_request(req.op, req.address, k == PHASE_REQUESTS - 1);
      end
    end
    quiet = 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
